// ----- hw/rtl/pcsrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsrt_pkg: shared types and codes of the per-class sorted record table.
// Holds the record layout, the operation codes and the cell control bundle.
// ----------------------------------------------------------------------------
package pcsrt_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_TAKE   = 3'd1,
    OP_SET    = 3'd2,
    OP_QUERY  = 3'd3,
    OP_RANK   = 3'd4,
    OP_COUNT  = 3'd5
  } op_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  cls;
    logic [15:0] qty;
    logic [15:0] val;
  } rec_t;

  // Control broadcast to every cell in the chain.
  typedef struct packed {
    logic        ins;     // shift in the key record at its sorted place
    logic        del;     // close the gap at the matching id
    rec_t        key;     // record to place
    logic [31:0] total;   // key quantity times unit value
    logic [15:0] del_id;  // id to remove
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_APPLY,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/per_class_sorted_record_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_sorted_record_table_unit: per-class sorted record table.
// A chain of cells keeps records ordered by class and total; requests are
// served one at a time by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  req     | valid ready opcode item_id item_class quantity | in
//          | unit_value rank                                |
//  rsp     | rsp_valid rsp_ready ok out_id out_quantity     | out
//          | out_unit_value entry_count                     |
//
// After accept, the prep state searches the chain for the id and the rank and
// forms the key total, and the apply state lets the cells insert or remove;
// the result is then registered and shown in the done state, and the unit
// returns to idle before the next accept. Take that leaves a nonzero
// quantity, and set, remove and then reinsert in a second apply pass.
// Reset empties every slot at once. The result holds while rsp_ready is low,
// and no new request is taken until it has gone.
// ----------------------------------------------------------------------------
module per_class_sorted_record_table_unit
  import pcsrt_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int NUM_TYPES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [2:0]  opcode,
  input  logic [15:0] item_id,
  input  logic [3:0]  item_class,
  input  logic [15:0] quantity,
  input  logic [15:0] unit_value,
  input  logic [5:0]  rank,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        ok,
  output logic [15:0] out_id,
  output logic [15:0] out_quantity,
  output logic [15:0] out_unit_value,
  output logic [6:0]  entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int RW = IW + 7;

  state_t      state, state_next;
  logic [2:0]  r_op;
  rec_t        r_in;
  logic [5:0]  r_rank;
  logic [CW-1:0] count;
  logic        reins;    // second pass of take or set

  cell_ctl_t   ctl;
  logic [CAPACITY-1:0] c_valid, c_ahead, c_gone, c_hit, c_cls;
  rec_t        c_rec [CAPACITY];

  // Chain of cells; the ends see an empty neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pcsrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .prev_valid  ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i - 1]),
      .prev_rec    (c_rec[(i == 0) ? 0 : i - 1]),
      .prev_ahead  ((i == 0) ? 1'b1 : c_ahead[(i == 0) ? 0 : i - 1]),
      .prev_gone   ((i == 0) ? 1'b0 : c_gone[(i == 0) ? 0 : i - 1]),
      .next_valid  ((i == CAPACITY - 1) ? 1'b0 : c_valid[(i == CAPACITY - 1) ? i : i + 1]),
      .next_rec    (c_rec[(i == CAPACITY - 1) ? i : i + 1]),
      .valid       (c_valid[i]),
      .rec         (c_rec[i]),
      .ahead       (c_ahead[i]),
      .gone        (c_gone[i])
    );
    assign c_hit[i] = c_valid[i] && (c_rec[i].id == r_in.id);
    assign c_cls[i] = c_valid[i] && (c_rec[i].cls == r_in.cls);
  end

  // Search results, registered in the prep cycle.
  logic        found;
  rec_t        frec;
  logic        rk_found;
  rec_t        rk_rec;
  logic [31:0] new_total;
  rec_t        new_rec;

  // Records of one class are contiguous, so the rank-th record of the class
  // sits at the class's first slot plus the rank, if that slot still holds
  // the class.
  logic [IW-1:0] first_idx;
  logic          cls_any;
  always_comb begin
    first_idx = '0;
    cls_any   = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (c_cls[i]) begin
        first_idx = IW'(i);
        cls_any   = 1'b1;
      end
    end
  end

  logic          hit_any;
  rec_t          hit_rec;
  always_comb begin
    hit_any = |c_hit;
    hit_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (c_hit[i]) begin
        hit_rec = c_rec[i];
      end
    end
  end

  logic [RW-1:0] rk_idx;
  assign rk_idx = RW'(first_idx) + RW'(r_rank);

  // Form the updated record from the search result.
  always_comb begin
    new_rec = r_in;
    case (r_op)
      OP_TAKE: begin
        new_rec     = frec;
        new_rec.qty = frec.qty - r_in.qty;
      end
      OP_SET: begin
        new_rec     = frec;
        new_rec.val = r_in.val;
      end
      default: new_rec = r_in;
    endcase
  end

  logic op_ok;
  always_comb begin
    case (r_op)
      OP_INSERT: op_ok = (32'(r_in.cls) < NUM_TYPES) && !found &&
                         (32'(count) < CAPACITY);
      OP_TAKE:   op_ok = found && (r_in.qty != 16'd0) && (r_in.qty <= frec.qty);
      OP_SET:    op_ok = found && (r_in.val != 16'd0);
      OP_QUERY:  op_ok = found;
      OP_RANK:   op_ok = rk_found;
      OP_COUNT:  op_ok = 1'b1;
      default:   op_ok = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (valid) state_next = ST_PREP;
      ST_PREP:  state_next = ST_APPLY;
      ST_APPLY: if (!(op_ok && !reins && ((r_op == OP_TAKE && new_rec.qty != 16'd0) ||
                                          r_op == OP_SET)))
                  state_next = ST_DONE;
      ST_DONE:  if (rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs and cell control.
  always_comb begin
    ready     = (state == ST_IDLE);
    rsp_valid = (state == ST_DONE);
    ctl       = '0;
    ctl.key   = new_rec;
    ctl.total = new_total;
    ctl.del_id = r_in.id;
    if (state == ST_APPLY && op_ok) begin
      if (r_op == OP_INSERT || reins) begin
        ctl.ins = 1'b1;
      end else if (r_op == OP_TAKE || r_op == OP_SET) begin
        ctl.del = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      reins <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.ins) count <= count + 1'b1;
      if (ctl.del) count <= count - 1'b1;
      if (state == ST_APPLY) reins <= (state_next == ST_APPLY);
    end
  end

  // Capture the request and the search.
  always_ff @(posedge clk) begin
    if (ready && valid) begin
      r_op       <= opcode;
      r_in.id    <= item_id;
      r_in.cls   <= item_class;
      r_in.qty   <= quantity;
      r_in.val   <= unit_value;
      r_rank     <= rank;
    end
    if (state == ST_PREP) begin
      found    <= hit_any;
      frec     <= hit_rec;
      rk_found <= (32'(r_in.cls) < NUM_TYPES) && cls_any &&
                  (32'(rk_idx) < CAPACITY) && c_cls[rk_idx[IW-1:0]];
      rk_rec   <= c_rec[rk_idx[IW-1:0]];
    end
  end

  // Total of the record to place, ready for the apply cycle.
  logic [31:0] key_total;
  always_comb begin
    key_total = 32'(r_in.qty) * 32'(r_in.val);
  end
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      new_total <= key_total;
    end else if (state == ST_APPLY) begin
      new_total <= 32'(new_rec.qty) * 32'(new_rec.val);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == ST_APPLY && state_next == ST_DONE) begin
      ok             <= op_ok || reins;
      out_id         <= (r_op == OP_RANK && rk_found) ? rk_rec.id : 16'd0;
      out_quantity   <= (r_op == OP_RANK && rk_found) ? rk_rec.qty : 16'd0;
      out_unit_value <= (r_op == OP_RANK && rk_found) ? rk_rec.val :
                        (r_op == OP_QUERY && found) ? frec.val : 16'd0;
    end
  end
  assign entry_count = 7'(count);

  // The table never holds more records than slots.
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= CAPACITY)
    else $error("record count past capacity");
  // Insert and remove never happen in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ctl.ins && ctl.del))
    else $error("insert and remove together");
  // A held result does not change.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(ok) && $stable(entry_count))
    else $error("result changed while stalled");

endmodule

// ----- hw/rtl/pcsrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsrt_cell: one slot of the sorted record chain.
// Compares the broadcast key against its record and takes its new content
// from itself, from the key or from a neighbor in the same cycle.
// ----------------------------------------------------------------------------
module pcsrt_cell
  import pcsrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      prev_valid,
  input  rec_t      prev_rec,
  input  logic      prev_ahead,
  input  logic      prev_gone,
  input  logic      next_valid,
  input  rec_t      next_rec,
  output logic      valid,
  output rec_t      rec,
  output logic      ahead,
  output logic      gone
);

  logic [31:0] total;
  logic        valid_next;
  rec_t        rec_next;

  // The product is stored with the record to keep the compare path short.
  always_ff @(posedge clk) begin
    if (valid_next) begin
      total <= 32'(rec_next.qty) * 32'(rec_next.val);
    end
  end

  // A valid record ahead of the key's place: lower class, or same class and
  // smaller total. Ordering makes this true over a prefix of the chain.
  assign ahead = valid && ((rec.cls < ctl.key.cls) ||
                 ((rec.cls == ctl.key.cls) && (total < ctl.total)));
  // Set at and past the removed id.
  assign gone = prev_gone || (valid && (rec.id == ctl.del_id));

  // Select the next content of the slot.
  always_comb begin
    valid_next = valid;
    rec_next   = rec;
    if (ctl.del && gone) begin
      valid_next = next_valid;
      rec_next   = next_rec;
    end else if (ctl.ins && !ahead) begin
      if (prev_ahead) begin
        valid_next = 1'b1;
        rec_next   = ctl.key;
      end else begin
        valid_next = prev_valid;
        rec_next   = prev_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule
